@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion macros shared by the RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

@@ src/csd_pkg.sv @@
// ----------------------------------------------------------------------------
// csd_pkg
// Types and sizing constants of the contour segment decomposer.
// ----------------------------------------------------------------------------
package csd_pkg;

  // sizing
  localparam int CONTOUR_POINTS = 64;
  localparam int COORD_BITS     = 16;
  localparam int PT_IDX_W       = $clog2(CONTOUR_POINTS);
  localparam int CNT_W          = $clog2(CONTOUR_POINTS + 1);
  localparam int STEP_W         = $clog2(2 * CONTOUR_POINTS);
  localparam int RAM_DEPTH      = 2 * CONTOUR_POINTS;
  localparam int RAM_AW         = PT_IDX_W + 1;
  localparam int PT_W           = 2 * COORD_BITS + 1;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  // input point
  typedef struct packed {
    coord_t x_coord;
    coord_t y_coord;
    logic   on_curve;
    logic   contour_end;
  } pt_in_t;

  // stored point
  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   on;
  } point_t;

  // output segment
  typedef struct packed {
    logic   seg_kind;
    coord_t first_x;
    coord_t first_y;
    coord_t second_x;
    coord_t second_y;
    coord_t third_x;
    coord_t third_y;
    logic   last_of_contour;
    logic   overflow;
  } seg_t;

  // closed contour waiting for the walk
  typedef struct packed {
    logic             bank;
    logic [CNT_W-1:0] n_points;
    logic             any_on;
    logic             ovf;
  } job_t;

  // point store write request
  typedef struct packed {
    logic              en;
    logic [RAM_AW-1:0] addr;
    point_t            data;
  } ram_wr_t;

endpackage

@@ src/csd_ram.sv @@
// ----------------------------------------------------------------------------
// csd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port, holds when idle
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ src/csd_front.sv @@
// ----------------------------------------------------------------------------
// csd_front
// Accepts points, writes them into the free bank and closes contours.
// ----------------------------------------------------------------------------
module csd_front import csd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    pt_valid,
  output logic    pt_stall,
  input  pt_in_t  pt_data,
  input  logic    q_full,
  output ram_wr_t ram_wr,
  output logic    push,
  output job_t    push_job
);

  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             any_on;
  logic             any_on_next;
  logic             ovf;
  logic             ovf_next;
  logic             bank;
  logic             accept;
  logic             room;

  // both banks busy: hold the producer
  assign pt_stall = q_full;
  assign accept   = pt_valid && !q_full;
  assign room     = count < CNT_W'(CONTOUR_POINTS);

  // store write
  assign ram_wr.en   = accept && room;
  assign ram_wr.addr = {bank, count[PT_IDX_W-1:0]};
  assign ram_wr.data = '{x: pt_data.x_coord, y: pt_data.y_coord, on: pt_data.on_curve};

  // contour state after this point
  assign count_next  = room ? count + 1'b1 : count;
  assign any_on_next = any_on | (room & pt_data.on_curve);
  assign ovf_next    = ovf | !room;

  // closing point hands the contour to the back end
  assign push     = accept && pt_data.contour_end;
  assign push_job = '{bank: bank, n_points: count_next, any_on: any_on_next, ovf: ovf_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      any_on <= 1'b0;
      ovf    <= 1'b0;
      bank   <= 1'b0;
    end else if (accept) begin
      if (pt_data.contour_end) begin
        count  <= '0;
        any_on <= 1'b0;
        ovf    <= 1'b0;
        bank   <= ~bank;
      end else begin
        count  <= count_next;
        any_on <= any_on_next;
        ovf    <= ovf_next;
      end
    end
  end

endmodule

@@ src/csd_job_queue.sv @@
// ----------------------------------------------------------------------------
// csd_job_queue
// Two-entry queue of closed contours, one per point store bank.
// ----------------------------------------------------------------------------
module csd_job_queue import csd_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic head_valid,
  output job_t head,
  output logic full
);

  job_t       entries [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] cnt;

  assign full       = cnt == 2'd2;
  assign head_valid = cnt != 2'd0;
  assign head       = entries[rd_ptr];

  // entry payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

@@ src/csd_back.sv @@
// ----------------------------------------------------------------------------
// csd_back
// Walks a stored contour and emits lines and quadratic Beziers.
// ----------------------------------------------------------------------------
module csd_back import csd_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              head_valid,
  input  job_t              head,
  output logic              pop,
  output logic              rd_en,
  output logic [RAM_AW-1:0] rd_addr,
  input  point_t            rd_data,
  output logic              seg_valid,
  input  logic              seg_stall,
  output seg_t              seg_data
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_READ = 2'd1;
  localparam logic [1:0] ST_PROC = 2'd2;

  localparam logic SEG_LINE = 1'b0;
  localparam logic SEG_QUAD = 1'b1;

  // midpoint rounded half away from zero
  function automatic coord_t mid_round(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] s;
    logic signed [COORD_BITS:0] s_p1;
    s    = {a[COORD_BITS-1], a} + {b[COORD_BITS-1], b};
    s_p1 = s + 1'b1;
    return s[COORD_BITS] ? s[COORD_BITS:1] : s_p1[COORD_BITS:1];
  endfunction

  logic [1:0]        state;
  logic [STEP_W-1:0] step;
  coord_t            start_x;
  coord_t            start_y;
  coord_t            ctrl_x;
  coord_t            ctrl_y;
  logic              have_ctrl;

  logic [STEP_W-1:0] n_ext;
  logic [STEP_W-1:0] idx_wide;
  logic              in_proc;
  logic              first_pt;
  logic              at_end;
  logic              need_emit;
  logic              slot_free;
  logic              go;
  logic              finish;
  logic              emit;
  coord_t            mid_x;
  coord_t            mid_y;
  seg_t              seg_next;

  // point index wraps within the contour
  assign n_ext    = STEP_W'(head.n_points);
  assign idx_wide = (step < n_ext) ? step : step - n_ext;
  assign rd_addr  = {head.bank, idx_wide[PT_IDX_W-1:0]};
  assign rd_en    = state == ST_READ;

  // walk step decisions
  assign in_proc   = state == ST_PROC;
  assign first_pt  = step == '0;
  assign at_end    = step >= n_ext;
  assign need_emit = !first_pt && (rd_data.on || have_ctrl);
  assign slot_free = !seg_valid || !seg_stall;
  assign go        = !need_emit || slot_free;
  assign emit      = in_proc && need_emit && slot_free;
  assign finish    = in_proc && go && !first_pt && rd_data.on && at_end;
  assign pop       = (state == ST_IDLE && head_valid && !head.any_on) || finish;

  assign mid_x = mid_round(ctrl_x, rd_data.x);
  assign mid_y = mid_round(ctrl_y, rd_data.y);

  // segment for the current point
  always_comb begin
    seg_next.seg_kind        = rd_data.on ? (have_ctrl ? SEG_QUAD : SEG_LINE) : SEG_QUAD;
    seg_next.first_x         = start_x;
    seg_next.first_y         = start_y;
    seg_next.second_x        = have_ctrl ? ctrl_x : rd_data.x;
    seg_next.second_y        = have_ctrl ? ctrl_y : rd_data.y;
    seg_next.third_x         = rd_data.on ? (have_ctrl ? rd_data.x : '0) : mid_x;
    seg_next.third_y         = rd_data.on ? (have_ctrl ? rd_data.y : '0) : mid_y;
    seg_next.last_of_contour = rd_data.on && at_end;
    seg_next.overflow        = head.ovf;
  end

  // sequencer and output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      have_ctrl <= 1'b0;
      seg_valid <= 1'b0;
    end else begin
      if (emit) begin
        seg_valid <= 1'b1;
      end else if (seg_valid && !seg_stall) begin
        seg_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (head_valid && head.any_on) begin
            state <= ST_READ;
          end
        end
        ST_READ: begin
          state <= ST_PROC;
        end
        ST_PROC: begin
          if (go) begin
            if (first_pt || rd_data.on) begin
              have_ctrl <= 1'b0;
            end else begin
              have_ctrl <= 1'b1;
            end
            state <= finish ? ST_IDLE : ST_READ;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // walk datapath
  always_ff @(posedge clk) begin
    if (emit) begin
      seg_data <= seg_next;
    end
    if (state == ST_IDLE) begin
      step <= '0;
    end else if (in_proc && go) begin
      step <= step + 1'b1;
      if (first_pt || rd_data.on) begin
        start_x <= rd_data.x;
        start_y <= rd_data.y;
      end else begin
        if (have_ctrl) begin
          start_x <= mid_x;
          start_y <= mid_y;
        end
        ctrl_x <= rd_data.x;
        ctrl_y <= rd_data.y;
      end
    end
  end

endmodule

@@ src/contour_segment_decomposer_core.sv @@
// An accepted point is written into the point store unless its contour is full; a
//   closing point queues the contour, which the walk reads back point by point.
// Points are accepted back to back while pt_stall is low; each point visited takes
//   one point store read and one step, n plus leading control points plus 1 steps.
// Two store banks let one contour load while the previous one is walked.
// Reset clears counters, queue and output valid; point store contents stay undefined.
// ----------------------------------------------------------------------------
// contour_segment_decomposer_core
// Splits closed outline contours into lines and quadratic Bezier segments.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module contour_segment_decomposer_core import csd_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   pt_valid,
  output logic   pt_stall,
  input  pt_in_t pt_data,
  output logic   seg_valid,
  input  logic   seg_stall,
  output seg_t   seg_data
);

  ram_wr_t           ram_wr;
  logic              push;
  job_t              push_job;
  logic              pop;
  logic              q_valid;
  job_t              q_head;
  logic              q_full;
  logic              rd_en;
  logic [RAM_AW-1:0] rd_addr;
  logic [PT_W-1:0]   rd_bits;
  point_t            rd_data;

  assign rd_data = rd_bits;

  // front: point intake
  csd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .pt_valid (pt_valid),
    .pt_stall (pt_stall),
    .pt_data  (pt_data),
    .q_full   (q_full),
    .ram_wr   (ram_wr),
    .push     (push),
    .push_job (push_job)
  );

  // double-banked point store
  csd_ram #(
    .WIDTH (PT_W),
    .DEPTH (RAM_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr.en),
    .wr_addr (ram_wr.addr),
    .wr_data (ram_wr.data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_bits)
  );

  // closed contours between front and back
  csd_job_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .pop        (pop),
    .head_valid (q_valid),
    .head       (q_head),
    .full       (q_full)
  );

  // back: contour walk
  csd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_valid),
    .head       (q_head),
    .pop        (pop),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .seg_valid  (seg_valid),
    .seg_stall  (seg_stall),
    .seg_data   (seg_data)
  );

  // front never writes the bank under walk
  `ASSERT_IMPLIES(a_bank_split, clk, rst, ram_wr.en && q_valid,
                  ram_wr.addr[RAM_AW-1] != q_head.bank, "store write hits bank being walked")

  // a closed contour is queued on the next cycle
  `ASSERT_NEXT(a_close_queued, clk, rst, pt_valid && !pt_stall && pt_data.contour_end,
               q_valid, "closed contour not queued")

  // segments only come from a pending contour
  `ASSERT_IMPLIES(a_seg_source, clk, rst, $rose(seg_valid), $past(q_valid),
                  "segment without pending contour")

endmodule
